FILE: design/aps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants of the aging priority scheduler
// Field widths, item and status codes, and the control structs that pass
// between the sequencer, the priority table and the ready queue.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int TASK_W        = 4;
    localparam int PRIO_W        = 8;
    localparam int REQ_W         = 6;
    localparam int CNT_W         = 5;
    localparam int TASK_IDS      = 1 << TASK_W;
    localparam int DEF_MAX_TASKS = 16;
    localparam int LIM_W         = 9;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_SET   = 2'd1,
        MODE_SCHED = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_DUP   = 2'd3
    } t_status;

    // priority table port: one shared address per cycle
    typedef struct packed {
        logic                     wr_static;
        logic                     wr_dynamic;
        logic                     set_queued;
        logic                     clr_queued;
        logic [TASK_W-1:0]        addr;
        logic signed [PRIO_W-1:0] static_data;
        logic signed [PRIO_W-1:0] dynamic_data;
    } t_tbl_cmd;

    typedef struct packed {
        logic                     hit;
        logic                     queued;
        logic signed [PRIO_W-1:0] static_prio;
        logic signed [PRIO_W-1:0] dynamic_prio;
    } t_tbl_rsp;

    // ready queue port: idx is the read slot, or the slot removed on pop
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [TASK_W-1:0] task_id;
        logic [CNT_W-1:0]  idx;
    } t_q_cmd;

endpackage

FILE: design/aging_priority_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_priority_scheduler_top: ready-queue scheduler with priority aging
// Sequencer plus one shared compare/age unit over the queued tasks.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Enqueue, set-priority and read beats pass
// through the EXEC and RESP states to the result register. A schedule
// beat passes through EXEC, one SCAN step per queued task (at most 16),
// PICK and RESP, because the single compare/age unit visits one queue
// slot per cycle, through the one shared port of the priority table.
// The input stalls while a beat is in work. The result register sits
// between the sequencer and the output, so the next beat is taken while
// a result still waits for the consumer; the sequencer only holds in its
// last step when that register is still full.
// Lower priority values are more urgent. A schedule picks the lowest
// dynamic priority (earliest in queue on ties), ages every queued task by
// one (saturating at -128), reloads the pick with static minus one and
// removes it from the queue. Task ids at or above MAX_TASKS are reported
// as queue full on enqueue and read back priority 0 otherwise.
// ----------------------------------------------------------------------------
module aging_priority_scheduler_top #(
    parameter int MAX_TASKS = aps_pkg::DEF_MAX_TASKS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beat
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic [aps_pkg::TASK_W-1:0]        i_task_index,
    input  logic signed [aps_pkg::REQ_W-1:0]  i_priority_req,
    // result beat
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [aps_pkg::TASK_W-1:0]        o_chosen_task,
    output logic [1:0]                        o_status,
    output logic signed [aps_pkg::PRIO_W-1:0] o_read_priority,
    output logic [aps_pkg::CNT_W-1:0]         o_queued_count
);

    // one-hot sequencer
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_PICK = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // latched beat
    aps_pkg::t_mode                    r_mode, n_mode;
    logic [aps_pkg::TASK_W-1:0]        r_task, n_task;
    logic signed [aps_pkg::REQ_W-1:0]  r_req, n_req;

    // scan state: running minimum
    logic [aps_pkg::CNT_W-1:0]         r_idx, n_idx;
    logic [aps_pkg::CNT_W-1:0]         r_best_idx, n_best_idx;
    logic [aps_pkg::TASK_W-1:0]        r_best_task, n_best_task;
    logic signed [aps_pkg::PRIO_W-1:0] r_best_prio, n_best_prio;

    // pending result
    logic [aps_pkg::TASK_W-1:0]        r_res_task, n_res_task;
    aps_pkg::t_status                  r_res_status, n_res_status;
    logic signed [aps_pkg::PRIO_W-1:0] r_res_prio, n_res_prio;
    logic [aps_pkg::TASK_W-1:0]        r_last, n_last;

    // output register
    logic                              r_out_valid, n_out_valid;
    logic [aps_pkg::TASK_W-1:0]        r_out_task, n_out_task;
    aps_pkg::t_status                  r_out_status, n_out_status;
    logic signed [aps_pkg::PRIO_W-1:0] r_out_prio, n_out_prio;
    logic [aps_pkg::CNT_W-1:0]         r_out_count, n_out_count;

    aps_pkg::t_tbl_cmd                 tbl_cmd;
    aps_pkg::t_tbl_rsp                 tbl_rsp;
    aps_pkg::t_q_cmd                   q_cmd;
    logic [aps_pkg::CNT_W-1:0]         q_count;
    logic                              q_full;
    logic [aps_pkg::TASK_W-1:0]        q_rd_task;

    logic                              in_accept;
    logic                              out_free;
    logic signed [aps_pkg::PRIO_W-1:0] req_ext;
    logic signed [aps_pkg::PRIO_W-1:0] cur_prio;
    logic signed [aps_pkg::PRIO_W-1:0] aged_prio;
    logic signed [aps_pkg::PRIO_W-1:0] reload_prio;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // shared compare/age unit operands
    assign req_ext     = {{(aps_pkg::PRIO_W - aps_pkg::REQ_W){r_req[aps_pkg::REQ_W-1]}}, r_req};
    assign cur_prio    = tbl_rsp.dynamic_prio;
    assign aged_prio   = (cur_prio == aps_pkg::PRIO_MIN) ? cur_prio : cur_prio - 8'sd1;
    assign reload_prio = tbl_rsp.static_prio - 8'sd1;

    aps_prio_table #(
        .MAX_TASKS (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_rsp   (tbl_rsp)
    );

    aps_ready_queue #(
        .MAX_TASKS (MAX_TASKS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_cmd),
        .o_count   (q_count),
        .o_full    (q_full),
        .o_rd_task (q_rd_task)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_task       = r_task;
        n_req        = r_req;
        n_idx        = r_idx;
        n_best_idx   = r_best_idx;
        n_best_task  = r_best_task;
        n_best_prio  = r_best_prio;
        n_res_task   = r_res_task;
        n_res_status = r_res_status;
        n_res_prio   = r_res_prio;
        n_last       = r_last;
        n_out_task   = r_out_task;
        n_out_status = r_out_status;
        n_out_prio   = r_out_prio;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid && i_out_stall;

        tbl_cmd      = '0;
        tbl_cmd.addr = r_task;
        q_cmd        = '0;
        q_cmd.task_id = r_task;
        q_cmd.idx    = r_idx;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_mode  = aps_pkg::t_mode'(i_mode);
                    n_task  = i_task_index;
                    n_req   = i_priority_req;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_task   = r_task;
                n_res_status = aps_pkg::STAT_OK;
                n_res_prio   = '0;
                n_state      = S_RESP;
                case (r_mode)
                    aps_pkg::MODE_ENQ: begin
                        n_res_prio = tbl_rsp.dynamic_prio;
                        if (!tbl_rsp.hit || q_full) begin
                            n_res_status = aps_pkg::STAT_FULL;
                        end else if (tbl_rsp.queued) begin
                            n_res_status = aps_pkg::STAT_DUP;
                        end else begin
                            q_cmd.push         = 1'b1;
                            tbl_cmd.set_queued = 1'b1;
                        end
                    end
                    aps_pkg::MODE_SET: begin
                        tbl_cmd.wr_static    = 1'b1;
                        tbl_cmd.wr_dynamic   = 1'b1;
                        tbl_cmd.static_data  = req_ext;
                        tbl_cmd.dynamic_data = req_ext;
                        n_res_prio = tbl_rsp.hit ? req_ext : '0;
                    end
                    aps_pkg::MODE_READ: begin
                        n_res_prio = tbl_rsp.static_prio;
                    end
                    aps_pkg::MODE_SCHED: begin
                        if (q_count == '0) begin
                            n_res_task   = r_last;
                            n_res_status = aps_pkg::STAT_EMPTY;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                // compare against the pre-aging value, then age it in place
                tbl_cmd.addr         = q_rd_task;
                tbl_cmd.wr_dynamic   = 1'b1;
                tbl_cmd.dynamic_data = aged_prio;
                if (r_idx == '0 || cur_prio < r_best_prio) begin
                    n_best_idx  = r_idx;
                    n_best_task = q_rd_task;
                    n_best_prio = cur_prio;
                end
                if (r_idx == q_count - 1'b1) begin
                    n_state = S_PICK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PICK: begin
                tbl_cmd.addr         = r_best_task;
                tbl_cmd.wr_dynamic   = 1'b1;
                tbl_cmd.dynamic_data = reload_prio;
                tbl_cmd.clr_queued   = 1'b1;
                q_cmd.pop            = 1'b1;
                q_cmd.idx            = r_best_idx;
                n_res_task   = r_best_task;
                n_res_status = aps_pkg::STAT_OK;
                n_res_prio   = reload_prio;
                n_last       = r_best_task;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_task   = r_res_task;
                    n_out_status = r_res_status;
                    n_out_prio   = r_res_prio;
                    n_out_count  = q_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_task       <= n_task;
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_best_idx   <= n_best_idx;
        r_best_task  <= n_best_task;
        r_best_prio  <= n_best_prio;
        r_res_task   <= n_res_task;
        r_res_status <= n_res_status;
        r_res_prio   <= n_res_prio;
        r_out_task   <= n_out_task;
        r_out_status <= n_out_status;
        r_out_prio   <= n_out_prio;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_task   = r_out_task;
    assign o_status        = r_out_status;
    assign o_read_priority = r_out_prio;
    assign o_queued_count  = r_out_count;

endmodule

FILE: design/aps_prio_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_prio_table: per-task static/dynamic priority and queued flag
// Single shared address; reads are combinational, writes land at the edge.
// ----------------------------------------------------------------------------
module aps_prio_table #(
    parameter int MAX_TASKS = aps_pkg::DEF_MAX_TASKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aps_pkg::t_tbl_cmd i_cmd,
    output aps_pkg::t_tbl_rsp o_rsp
);

    localparam int NUM_SLOTS = (MAX_TASKS < aps_pkg::TASK_IDS) ? MAX_TASKS
                                                               : aps_pkg::TASK_IDS;
    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [aps_pkg::LIM_W-1:0] MAX_LIM = aps_pkg::LIM_W'(MAX_TASKS);

    logic signed [aps_pkg::PRIO_W-1:0] r_static  [NUM_SLOTS];
    logic signed [aps_pkg::PRIO_W-1:0] r_dynamic [NUM_SLOTS];
    logic        [NUM_SLOTS-1:0]       r_queued;

    logic             hit;
    logic [IDX_W-1:0] idx;

    assign hit = {{(aps_pkg::LIM_W - aps_pkg::TASK_W){1'b0}}, i_cmd.addr} < MAX_LIM;
    assign idx = i_cmd.addr[IDX_W-1:0];

    always_comb begin
        o_rsp = '0;
        o_rsp.hit = hit;
        if (hit) begin
            o_rsp.queued       = r_queued[idx];
            o_rsp.static_prio  = r_static[idx];
            o_rsp.dynamic_prio = r_dynamic[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_static[k]  <= '0;
                r_dynamic[k] <= '0;
            end
            r_queued <= '0;
        end else if (hit) begin
            if (i_cmd.wr_static)  r_static[idx]  <= i_cmd.static_data;
            if (i_cmd.wr_dynamic) r_dynamic[idx] <= i_cmd.dynamic_data;
            if (i_cmd.set_queued) r_queued[idx]  <= 1'b1;
            if (i_cmd.clr_queued) r_queued[idx]  <= 1'b0;
        end
    end

endmodule

FILE: design/aps_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_ready_queue: ready queue of task ids in arrival order
// Push at the tail, remove any slot with a single compaction shift.
// ----------------------------------------------------------------------------
module aps_ready_queue #(
    parameter int MAX_TASKS = aps_pkg::DEF_MAX_TASKS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  aps_pkg::t_q_cmd            i_cmd,
    output logic [aps_pkg::CNT_W-1:0]  o_count,
    output logic                       o_full,
    output logic [aps_pkg::TASK_W-1:0] o_rd_task
);

    localparam int NUM_SLOTS = (MAX_TASKS < aps_pkg::TASK_IDS) ? MAX_TASKS
                                                               : aps_pkg::TASK_IDS;
    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [aps_pkg::LIM_W-1:0] MAX_LIM = aps_pkg::LIM_W'(MAX_TASKS);

    // contents are only meaningful below r_count; no reset
    logic [aps_pkg::TASK_W-1:0] r_order [NUM_SLOTS];
    logic [aps_pkg::CNT_W-1:0]  r_count;

    assign o_count   = r_count;
    assign o_full    = {{(aps_pkg::LIM_W - aps_pkg::CNT_W){1'b0}}, r_count} >= MAX_LIM;
    assign o_rd_task = r_order[i_cmd.idx[IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_order[r_count[IDX_W-1:0]] <= i_cmd.task_id;
        end
        if (i_cmd.pop) begin
            for (int j = 0; j < NUM_SLOTS - 1; j++) begin
                if (aps_pkg::CNT_W'(j) >= i_cmd.idx && aps_pkg::CNT_W'(j + 1) < r_count) begin
                    r_order[j] <= r_order[j + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.pop) begin
            r_count <= r_count - 1'b1;
        end
    end

endmodule

FILE: design/aps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_checker: port-level checks for the aging priority scheduler
// Watches both beat channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module aps_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [aps_pkg::TASK_W-1:0]        o_chosen_task,
    input logic [1:0]                        o_status,
    input logic signed [aps_pkg::PRIO_W-1:0] o_read_priority,
    input logic [aps_pkg::CNT_W-1:0]         o_queued_count
);

    // reset empties the result register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a beat in work blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // an empty-queue schedule reports nothing queued and priority zero
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == aps_pkg::STAT_EMPTY) |->
            (o_queued_count == '0 && o_read_priority == '0))
        else $error("empty schedule result inconsistent");

    // never more queued tasks than ids exist
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_queued_count <= aps_pkg::CNT_W'(aps_pkg::TASK_IDS)))
        else $error("queued count out of range");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_chosen_task) && $stable(o_status) &&
             $stable(o_read_priority) && $stable(o_queued_count)))
        else $error("stalled result beat changed");

endmodule

bind aging_priority_scheduler_top aps_checker u_aps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_chosen_task   (o_chosen_task),
    .o_status        (o_status),
    .o_read_priority (o_read_priority),
    .o_queued_count  (o_queued_count)
);

FILE: dv/aps_sched_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aps_sched_sb_pkg: ready-queue predictor and answer scoreboard
// Tracks the scheduler's queue and priority tables beat by beat and holds
// the answers the block owes, oldest first.
// ----------------------------------------------------------------------------
package aps_sched_sb_pkg;

    import aps_pkg::*;

    localparam int SCHED_SLOTS = DEF_MAX_TASKS;

    typedef struct {
        logic [TASK_W-1:0]        task_id;
        t_status                  status;
        logic signed [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]         count;
    } t_answer;

    class sched_scoreboard;

        logic [TASK_W-1:0]        ready_order [SCHED_SLOTS];
        int unsigned              ready_len;
        logic signed [PRIO_W-1:0] static_prio [SCHED_SLOTS];
        logic signed [PRIO_W-1:0] dyn_prio [SCHED_SLOTS];
        bit                       queued [SCHED_SLOTS];
        logic [TASK_W-1:0]        last_pick;
        t_answer                  pending_answers [$];
        int unsigned              fail_count;

        function new();
            for (int i = 0; i < SCHED_SLOTS; i++) begin
                ready_order[i] = '0;
                static_prio[i] = '0;
                dyn_prio[i]    = '0;
                queued[i]      = 1'b0;
            end
            ready_len  = 0;
            last_pick  = '0;
            fail_count = 0;
        endfunction

        // advance the tables by one accepted beat and queue the answer it owes
        function void apply_request(t_mode mode, logic [TASK_W-1:0] idx,
                                    logic signed [REQ_W-1:0] req);
            t_answer                  ans;
            bit                       idx_ok;
            int unsigned              best;
            logic [TASK_W-1:0]        pick;
            logic signed [PRIO_W-1:0] wide_req;
            idx_ok      = (idx < SCHED_SLOTS);
            wide_req    = PRIO_W'(req);
            ans.task_id = idx;
            ans.status  = STAT_OK;
            ans.prio    = '0;
            case (mode)
                MODE_ENQ: begin
                    if (!idx_ok || ready_len >= SCHED_SLOTS) begin
                        ans.status = STAT_FULL;
                        if (idx_ok) ans.prio = dyn_prio[idx];
                    end else if (queued[idx]) begin
                        ans.status = STAT_DUP;
                        ans.prio   = dyn_prio[idx];
                    end else begin
                        ready_order[ready_len] = idx;
                        ready_len++;
                        queued[idx] = 1'b1;
                        ans.prio    = dyn_prio[idx];
                    end
                end
                MODE_SET: begin
                    if (idx_ok) begin
                        static_prio[idx] = wide_req;
                        dyn_prio[idx]    = wide_req;
                        ans.prio         = wide_req;
                    end
                end
                MODE_READ: begin
                    if (idx_ok) ans.prio = static_prio[idx];
                end
                default: begin
                    if (ready_len == 0) begin
                        ans.task_id = last_pick;
                        ans.status  = STAT_EMPTY;
                    end else begin
                        best = 0;
                        for (int unsigned i = 1; i < ready_len; i++)
                            if (dyn_prio[ready_order[i]] < dyn_prio[ready_order[best]])
                                best = i;
                        // age everything still waiting, floor at the minimum
                        for (int unsigned i = 0; i < ready_len; i++)
                            if (dyn_prio[ready_order[i]] != PRIO_MIN)
                                dyn_prio[ready_order[i]] -= 8'sd1;
                        pick           = ready_order[best];
                        dyn_prio[pick] = static_prio[pick] - 8'sd1;
                        queued[pick]   = 1'b0;
                        for (int unsigned i = best; i + 1 < ready_len; i++)
                            ready_order[i] = ready_order[i + 1];
                        ready_len--;
                        last_pick   = pick;
                        ans.task_id = pick;
                        ans.prio    = dyn_prio[pick];
                    end
                end
            endcase
            ans.count = CNT_W'(ready_len);
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(logic [TASK_W-1:0] task_id, logic [1:0] status,
                                   logic signed [PRIO_W-1:0] prio,
                                   logic [CNT_W-1:0] count);
            t_answer exp_ans;
            if (pending_answers.size() == 0) begin
                $display("%0t: result beat with no answer pending (task %0d status %0d)",
                         $time, task_id, status);
                fail_count++;
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (exp_ans.task_id !== task_id) begin
                $display("%0t: chosen_task expected %0d got %0d",
                         $time, exp_ans.task_id, task_id);
                fail_count++;
            end
            if (exp_ans.status !== t_status'(status)) begin
                $display("%0t: status expected %0d got %0d",
                         $time, exp_ans.status, status);
                fail_count++;
            end
            if (exp_ans.prio !== prio) begin
                $display("%0t: read_priority expected %0d got %0d",
                         $time, exp_ans.prio, prio);
                fail_count++;
            end
            if (exp_ans.count !== count) begin
                $display("%0t: queued_count expected %0d got %0d",
                         $time, exp_ans.count, count);
                fail_count++;
            end
        endfunction

    endclass

endpackage

FILE: dv/aging_priority_scheduler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_priority_scheduler_top_tb: self-checking bench for the scheduler
// Drives enqueue, set, read and schedule beats, predicts every answer from
// a model of the ready queue and priority tables, and checks each result
// beat field by field under several idle and backpressure mixes.
// ----------------------------------------------------------------------------
module aging_priority_scheduler_top_tb;

    import aps_pkg::*;
    import aps_sched_sb_pkg::*;

    // the limit leaves lots of headroom over the slowest legal run
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned ITEMS_PER_PASS = 270;
    // a schedule beat over a full queue scans every slot, plus the
    // output register; this covers it with margin
    localparam int unsigned TAIL_CYCLES  = 60;

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     in_valid       = 1'b0;
    logic                     in_stall;
    logic [1:0]               mode           = '0;
    logic [TASK_W-1:0]        task_index     = '0;
    logic signed [REQ_W-1:0]  priority_req   = '0;
    logic                     out_valid;
    logic                     out_stall      = 1'b0;
    logic [TASK_W-1:0]        chosen_task;
    logic [1:0]               status;
    logic signed [PRIO_W-1:0] read_priority;
    logic [CNT_W-1:0]         queued_count;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned cycles    = 0;

    sched_scoreboard sb = new();

    aging_priority_scheduler_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_mode          (mode),
        .i_task_index    (task_index),
        .i_priority_req  (priority_req),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_chosen_task   (chosen_task),
        .o_status        (status),
        .o_read_priority (read_priority),
        .o_queued_count  (queued_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("aging_priority_scheduler_top_tb failed");
            $finish;
        end
    end

    // Receiver: random backpressure, redrawn every falling edge.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: values seen here are the pre-edge ones, since all drives
    // happen on the falling edge. Results are checked before the input beat
    // of the same edge is applied; a result can never belong to that beat.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_answer(chosen_task, status, read_priority, queued_count);
            if (in_valid && !in_stall)
                sb.apply_request(t_mode'(mode), task_index, priority_req);
        end
    end

    // Present one beat and hold it until taken. Entered and left on a
    // falling edge; valid gets one assignment per edge at most, so back to
    // back beats keep valid high without a glitch.
    task automatic send_beat(input t_mode m, input int unsigned idx, input int req);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        task_index   <= TASK_W'(idx);
        priority_req <= REQ_W'(req);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off the sender until every owed answer has come back.
    task automatic drain_answers();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending_answers.size() != 0);
    endtask

    // Random beat. Enqueue weight swings every 60 beats so the queue
    // alternates between running dry and sitting full. Priorities cluster
    // near zero half the time so that ties and the queue-order tie break
    // come up often.
    task automatic send_random(input int unsigned n);
        int unsigned enq_w;
        int unsigned r;
        int          req;
        enq_w = ((n / 60) % 2 == 0) ? 50 : 22;
        r     = $urandom_range(99);
        if ($urandom_range(1) == 0)
            req = int'($urandom_range(4)) - 2;
        else
            req = int'($urandom_range(63)) - 32;
        if (r < enq_w)
            send_beat(MODE_ENQ, $urandom_range(15), req);
        else if (r < enq_w + 30)
            send_beat(MODE_SCHED, $urandom_range(15), req);
        else if (r < enq_w + 40)
            send_beat(MODE_SET, $urandom_range(15), req);
        else
            send_beat(MODE_READ, $urandom_range(15), req);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part, no idling ----
        // schedule on an empty queue reports the last pick (zero after reset)
        send_beat(MODE_SCHED, 9, 0);
        send_beat(MODE_READ, 15, 0);
        // priority extremes: most urgent, least urgent, all-ones
        send_beat(MODE_SET, 0, -32);
        send_beat(MODE_SET, 15, 31);
        send_beat(MODE_SET, 5, -1);
        // fill the queue with every task id
        for (int i = 0; i < 16; i++)
            send_beat(MODE_ENQ, i, 0);
        // full queue beats the duplicate check
        send_beat(MODE_ENQ, 7, 0);
        // most urgent task leaves; everyone else ages
        send_beat(MODE_SCHED, 0, 0);
        // already queued
        send_beat(MODE_ENQ, 3, 0);
        send_beat(MODE_READ, 0, 0);
        drain_answers();

        // ---- random part, four idling mixes ----
        for (int pass_no = 0; pass_no < 4; pass_no++) begin
            case (pass_no)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            for (int n = 0; n < ITEMS_PER_PASS; n++)
                send_random(n);
            // sender waits out every pending answer between mixes
            drain_answers();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending_answers.size() == 0) begin
            $display("aging_priority_scheduler_top_tb passed");
        end else begin
            $display("aging_priority_scheduler_top_tb failed");
        end
        $finish;
    end

endmodule
